// ----- design/mfu_pkg.sv -----
// Shared types and constants for the motor feedback unwrap block.
// Holds the beat structs, the register map and the reset values.
// Depends on nothing; every other file imports it.
`default_nettype none

package mfu_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int NumSlotsDef = 11;
    localparam int PosWidthDef = 32;

    // Feedback identifier window.
    localparam logic [10:0] FirstId = 11'h201;
    localparam logic [10:0] LastId  = 11'h20B;

    // Field widths fixed by the frame format.
    localparam int AngleW   = 16;
    localparam int FiltW    = 24;
    localparam int MaskW    = 11;
    localparam int CoefW    = 9;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 11;

    // Encoder sizes in counts per turn and their halves.
    localparam logic signed [17:0] EncNarrow     = 18'sd8192;
    localparam logic signed [17:0] EncWide       = 18'sd16384;
    localparam logic signed [17:0] EncHalfNarrow = 18'sd4096;
    localparam logic signed [17:0] EncHalfWide   = 18'sd8192;

    // Q8 filter weights.
    localparam logic [CoefW-1:0] Q8One            = 9'd256;
    localparam logic [CoefW-1:0] SpeedCoefReset   = 9'd218;
    localparam logic [CoefW-1:0] CurrentCoefReset = 9'd230;

    // Register map.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SLOT_ENABLE  = 8'd0,
        CFG_SLOT_WIDE    = 8'd1,
        CFG_SPEED_COEF   = 8'd2,
        CFG_CURRENT_COEF = 8'd3
    } t_cfg_index;

    typedef struct packed {
        logic [MaskW-1:0] slot_enable;
        logic [MaskW-1:0] slot_wide;
        logic [CoefW-1:0] speed_coef;
        logic [CoefW-1:0] current_coef;
    } t_cfg_regs;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte_angle_high;
        logic [7:0]  byte_angle_low;
        logic [7:0]  byte_speed_high;
        logic [7:0]  byte_speed_low;
        logic [7:0]  byte_current_high;
        logic [7:0]  byte_current_low;
        logic [7:0]  byte_temperature;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]              slot;
        logic [AngleW-1:0]       angle_counts;
        logic signed [31:0]      position_counts;
        logic signed [FiltW-1:0] speed_filtered;
        logic signed [FiltW-1:0] current_filtered;
        logic [7:0]              temperature;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- design/motor_feedback_unwrap.sv -----
// Motor feedback unwrap: decodes feedback frames, unwraps encoder angle.
// Path: an accepted frame's result passes through the update stage register and
// then the output register, waiting while the output is back-pressured.
// Throughput: one frame per cycle unless the output stalls, set by the slot entry
// read-modify-write in the state RAM, with forwarding between back-to-back frames.
// Reset (synchronous, active low) clears all seen flags, so every slot reads
// as zero state; no clearing pass is needed. Depends on mfu_pkg and submodules.
`default_nettype none

module motor_feedback_unwrap
    import mfu_pkg::*;
#(
    parameter int NUM_SLOTS      = NumSlotsDef,
    parameter int POSITION_WIDTH = PosWidthDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_beat            i_in_beat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_beat                o_out_beat,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    localparam int AddrW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EntryW = AngleW + POSITION_WIDTH + 2 * FiltW;

    t_cfg_regs cfg;

    // Input decode.
    logic [10:0] id_off;
    logic [3:0]  in_slot;
    logic        in_range;
    logic        in_hit;
    logic        in_accept;
    logic        rd_en;

    // Update stage.
    logic                      r_s1_valid;
    logic [3:0]                r_s1_slot;
    logic [AngleW-1:0]         r_s1_angle;
    logic signed [15:0]        r_s1_speed;
    logic signed [15:0]        r_s1_current;
    logic [7:0]                r_s1_temp;
    logic                      s1_adv;
    logic                      rd_seen;
    logic [EntryW-1:0]         rd_data;
    logic [EntryW-1:0]         wr_data;
    logic [AngleW-1:0]         old_angle;
    logic [POSITION_WIDTH-1:0] old_pos;
    logic signed [FiltW-1:0]   old_speed;
    logic signed [FiltW-1:0]   old_current;
    logic [POSITION_WIDTH-1:0] new_pos;
    logic signed [FiltW-1:0]   new_speed;
    logic signed [FiltW-1:0]   new_current;
    logic [63:0]               pos_ext;

    // Output register.
    logic      r_out_valid;
    t_out_beat r_out_beat;

    mfu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Identifier window, slot bound and enable bit.
    assign id_off   = i_in_beat.frame_id - FirstId;
    assign in_slot  = id_off[3:0];
    assign in_range = (i_in_beat.frame_id >= FirstId) && (i_in_beat.frame_id <= LastId)
                      && (32'(in_slot) < NUM_SLOTS);
    assign in_hit   = in_range ? cfg.slot_enable[in_slot] : 1'b0;

    // Handshake: the update stage moves on when the output register frees up.
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign rd_en      = in_accept && in_hit;

    mfu_state_ram #(
        .NUM_SLOTS (NUM_SLOTS),
        .ADDR_W    (AddrW),
        .DATA_W    (EntryW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (in_slot[AddrW-1:0]),
        .o_rd_seen (rd_seen),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_slot[AddrW-1:0]),
        .i_wr_data (wr_data)
    );

    // Update stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rd_en) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Update stage payload, captured with the RAM read.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_slot    <= in_slot;
            r_s1_angle   <= {i_in_beat.byte_angle_high, i_in_beat.byte_angle_low};
            r_s1_speed   <= {i_in_beat.byte_speed_high, i_in_beat.byte_speed_low};
            r_s1_current <= {i_in_beat.byte_current_high, i_in_beat.byte_current_low};
            r_s1_temp    <= i_in_beat.byte_temperature;
        end
    end

    // Entry layout: last angle, position, speed state, current state.
    assign {old_angle, old_pos, old_speed, old_current} = rd_data;

    mfu_update #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_update (
        .i_seen          (rd_seen),
        .i_wide          (cfg.slot_wide[r_s1_slot]),
        .i_angle         (r_s1_angle),
        .i_speed         (r_s1_speed),
        .i_current       (r_s1_current),
        .i_speed_coef    (cfg.speed_coef),
        .i_current_coef  (cfg.current_coef),
        .i_last_angle    (old_angle),
        .i_pos           (old_pos),
        .i_speed_state   (old_speed),
        .i_current_state (old_current),
        .o_pos           (new_pos),
        .o_speed_state   (new_speed),
        .o_current_state (new_current)
    );

    assign wr_data = {r_s1_angle, new_pos, new_speed, new_current};
    assign pos_ext = 64'(new_pos);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_beat.slot             <= r_s1_slot;
            r_out_beat.angle_counts     <= r_s1_angle;
            r_out_beat.position_counts  <= pos_ext[31:0];
            r_out_beat.speed_filtered   <= new_speed;
            r_out_beat.current_filtered <= new_current;
            r_out_beat.temperature      <= r_s1_temp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

// ----- design/mfu_cfg_regs.sv -----
// Configuration register file of the motor feedback unwrap block.
// Decodes register writes by index; unknown indexes are dropped.
// Depends on mfu_pkg.
`default_nettype none

module mfu_cfg_regs
    import mfu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg_regs                o_cfg
);

    t_cfg_regs r_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_enable  <= '0;
            r_cfg.slot_wide    <= '0;
            r_cfg.speed_coef   <= SpeedCoefReset;
            r_cfg.current_coef <= CurrentCoefReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLOT_ENABLE:  r_cfg.slot_enable  <= i_cfg_data[MaskW-1:0];
                CFG_SLOT_WIDE:    r_cfg.slot_wide    <= i_cfg_data[MaskW-1:0];
                CFG_SPEED_COEF:   r_cfg.speed_coef   <= i_cfg_data[CoefW-1:0];
                CFG_CURRENT_COEF: r_cfg.current_coef <= i_cfg_data[CoefW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/mfu_state_ram.sv -----
// Per-slot state memory: synchronous RAM with a registered read,
// seen flags in flip-flops and forwarding of the last write-back.
// Depends on mfu_pkg.
`default_nettype none

module mfu_state_ram
    import mfu_pkg::*;
#(
    parameter int NUM_SLOTS = NumSlotsDef,
    parameter int ADDR_W    = 4,
    parameter int DATA_W    = 96
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic                   o_rd_seen,
    output logic [DATA_W-1:0]      o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0]    r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_seen;
    logic [DATA_W-1:0]    r_rd_q;
    logic [ADDR_W-1:0]    r_rd_addr;
    logic                 r_wb_valid;
    logic [ADDR_W-1:0]    r_wb_addr;
    logic [DATA_W-1:0]    r_wb_data;
    logic                 fwd_hit;

    // Storage array: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // Seen flags, read address and the last write-back for forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_rd_addr  <= '0;
            r_wb_valid <= 1'b0;
            r_wb_addr  <= '0;
        end else begin
            if (i_rd_en) begin
                r_rd_addr <= i_rd_addr;
            end
            if (i_wr_en) begin
                r_seen[i_wr_addr] <= 1'b1;
                r_wb_valid        <= 1'b1;
                r_wb_addr         <= i_wr_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wb_data <= i_wr_data;
        end
    end

    // A write landing on the edge of the read leaves the RAM output stale,
    // so the last write-back overrides it. An unseen entry reads as zero.
    assign o_rd_seen = r_seen[r_rd_addr];
    assign fwd_hit   = r_wb_valid && (r_wb_addr == r_rd_addr);

    always_comb begin
        if (!o_rd_seen) begin
            o_rd_data = '0;
        end else if (fwd_hit) begin
            o_rd_data = r_wb_data;
        end else begin
            o_rd_data = r_rd_q;
        end
    end

endmodule

`default_nettype wire

// ----- design/mfu_update.sv -----
// Slot update datapath: angle unwrap into the multi-turn accumulator
// and the two first-order Q8 filters. Depends on mfu_pkg.
`default_nettype none

module mfu_update
    import mfu_pkg::*;
#(
    parameter int POSITION_WIDTH = PosWidthDef
) (
    input  wire logic                      i_seen,
    input  wire logic                      i_wide,
    input  wire logic [AngleW-1:0]         i_angle,
    input  wire logic signed [15:0]        i_speed,
    input  wire logic signed [15:0]        i_current,
    input  wire logic [CoefW-1:0]          i_speed_coef,
    input  wire logic [CoefW-1:0]          i_current_coef,
    input  wire logic [AngleW-1:0]         i_last_angle,
    input  wire logic [POSITION_WIDTH-1:0] i_pos,
    input  wire logic signed [FiltW-1:0]   i_speed_state,
    input  wire logic signed [FiltW-1:0]   i_current_state,
    output logic [POSITION_WIDTH-1:0]      o_pos,
    output logic signed [FiltW-1:0]        o_speed_state,
    output logic signed [FiltW-1:0]        o_current_state
);

    logic [AngleW-1:0]  last_eff;
    logic signed [17:0] delta_raw;
    logic signed [17:0] delta;
    logic signed [17:0] half;
    logic signed [17:0] size;

    // new = floor((256*old + c*(sample*256 - old) + 128) / 256), saturated.
    function automatic logic signed [FiltW-1:0] smooth(
        input logic signed [FiltW-1:0] old,
        input logic signed [15:0]      sample,
        input logic [CoefW-1:0]        coef
    );
        logic [CoefW-1:0]   c_sat;
        logic signed [9:0]  c_s;
        logic signed [24:0] diff;
        logic signed [34:0] prod;
        logic signed [35:0] acc;
        logic signed [27:0] q;
        c_sat = (coef > Q8One) ? Q8One : coef;
        c_s   = $signed({1'b0, c_sat});
        diff  = $signed({sample[15], sample, 8'b0}) - $signed({old[FiltW-1], old});
        prod  = diff * c_s;
        acc   = $signed({{4{old[FiltW-1]}}, old, 8'b0}) + 36'(prod) + 36'sd128;
        q     = acc[35:8];
        if (q[27:23] == 5'b00000 || q[27:23] == 5'b11111) begin
            smooth = q[FiltW-1:0];
        end else if (q[27]) begin
            smooth = {1'b1, {(FiltW-1){1'b0}}};
        end else begin
            smooth = {1'b0, {(FiltW-1){1'b1}}};
        end
    endfunction

    // The first frame of a slot seeds the last angle, so its delta is zero.
    assign last_eff  = i_seen ? i_last_angle : i_angle;
    assign delta_raw = $signed({2'b00, i_angle}) - $signed({2'b00, last_eff});
    assign half      = i_wide ? EncHalfWide : EncHalfNarrow;
    assign size      = i_wide ? EncWide : EncNarrow;

    // Single wrap correction by one encoder turn.
    always_comb begin
        if (delta_raw < -half) begin
            delta = delta_raw + size;
        end else if (delta_raw > half) begin
            delta = delta_raw - size;
        end else begin
            delta = delta_raw;
        end
    end

    // Accumulator wraps in two's complement; cleared on the first frame.
    assign o_pos = i_seen ? (i_pos + {{(POSITION_WIDTH-18){delta[17]}}, delta})
                          : '0;

    assign o_speed_state   = smooth(i_speed_state, i_speed, i_speed_coef);
    assign o_current_state = smooth(i_current_state, i_current, i_current_coef);

endmodule

`default_nettype wire

// ----- dv/motor_feedback_unwrap_chk.sv -----
`timescale 1ns / 1ps
// Checker for the motor feedback unwrap block: watches the frame, result and
// register channels, predicts each result and compares it field by field.
// Depends on mfu_pkg for the beat structs, the register map and the constants.
`default_nettype none

module motor_feedback_unwrap_chk
    import mfu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire t_in_beat            i_in_beat,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire t_out_beat           i_out_beat,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    // Register copy and per-slot tracking state.
    t_cfg_regs                 regs;
    logic                      slot_seen  [NumSlotsDef];
    logic [AngleW-1:0]         prev_angle [NumSlotsDef];
    logic [31:0]               turn_pos   [NumSlotsDef];
    logic signed [FiltW-1:0]   speed_lp   [NumSlotsDef];
    logic signed [FiltW-1:0]   current_lp [NumSlotsDef];

    // Results predicted but not yet seen on the output, oldest first.
    t_out_beat pending_feedback[$];

    // First-order Q8 low-pass step, rounded half up and clamped to the filter width.
    function automatic logic signed [FiltW-1:0] lowpass(input logic signed [FiltW-1:0] prev,
                                                        input logic signed [15:0] sample,
                                                        input logic [CoefW-1:0] coef);
        longint one;
        longint weight;
        longint acc;
        longint hi_lim;
        longint lo_lim;
        one    = longint'(Q8One);
        weight = (coef > Q8One) ? longint'(Q8One) : longint'(coef);
        hi_lim = (longint'(1) << (FiltW - 1)) - 1;
        lo_lim = -hi_lim - 1;
        acc = (one - weight) * longint'(prev) + weight * longint'(sample) * one + one / 2;
        acc = acc >>> 8;
        if (acc > hi_lim) begin
            acc = hi_lim;
        end
        if (acc < lo_lim) begin
            acc = lo_lim;
        end
        return acc[FiltW-1:0];
    endfunction

    // Decodes one frame against the slot state. Returns 1 and the result when
    // the frame targets an enabled slot; the state is left alone otherwise.
    function automatic logic unwrap_frame(input t_in_beat f, output t_out_beat r);
        int                slot_idx;
        int                span;
        int                delta;
        logic [AngleW-1:0] angle;
        r = '0;
        if (f.frame_id < FirstId || f.frame_id > LastId) begin
            return 1'b0;
        end
        slot_idx = int'(f.frame_id - FirstId);
        if (slot_idx >= NumSlotsDef || !regs.slot_enable[slot_idx]) begin
            return 1'b0;
        end
        angle = {f.byte_angle_high, f.byte_angle_low};
        span  = regs.slot_wide[slot_idx] ? int'(EncWide) : int'(EncNarrow);

        // The first frame of a slot anchors the unwrap at its own angle.
        if (!slot_seen[slot_idx]) begin
            slot_seen[slot_idx]  = 1'b1;
            prev_angle[slot_idx] = angle;
            turn_pos[slot_idx]   = '0;
        end

        // One wrap correction only; angles beyond the encoder span are not folded.
        delta = int'(angle) - int'(prev_angle[slot_idx]);
        if (delta < -(span / 2)) begin
            delta = delta + span;
        end else if (delta > span / 2) begin
            delta = delta - span;
        end
        prev_angle[slot_idx] = angle;
        turn_pos[slot_idx]   = turn_pos[slot_idx] + delta;

        speed_lp[slot_idx] = lowpass(speed_lp[slot_idx],
                                     $signed({f.byte_speed_high, f.byte_speed_low}),
                                     regs.speed_coef);
        current_lp[slot_idx] = lowpass(current_lp[slot_idx],
                                       $signed({f.byte_current_high, f.byte_current_low}),
                                       regs.current_coef);

        r.slot             = slot_idx[3:0];
        r.angle_counts     = angle;
        r.position_counts  = turn_pos[slot_idx];
        r.speed_filtered   = speed_lp[slot_idx];
        r.current_filtered = current_lp[slot_idx];
        r.temperature      = f.byte_temperature;
        return 1'b1;
    endfunction

    task automatic report(input string name, input longint want, input longint got);
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        o_fail_count++;
    endtask

    // All three channels are sampled at the rising edge. A result can never
    // belong to a frame accepted on the same edge, so results are matched first.
    always @(posedge i_clk) begin : track
        t_out_beat want;
        if (!i_rst_n) begin
            regs.slot_enable  = '0;
            regs.slot_wide    = '0;
            regs.speed_coef   = SpeedCoefReset;
            regs.current_coef = CurrentCoefReset;
            for (int i = 0; i < NumSlotsDef; i++) begin
                slot_seen[i]  = 1'b0;
                prev_angle[i] = '0;
                turn_pos[i]   = '0;
                speed_lp[i]   = '0;
                current_lp[i] = '0;
            end
            pending_feedback.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Result beat against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (pending_feedback.size() == 0) begin
                    $error("result beat for slot %0d with no frame waiting", i_out_beat.slot);
                    o_fail_count++;
                end else begin
                    want = pending_feedback.pop_front();
                    o_checked++;
                    if (i_out_beat.slot != want.slot) begin
                        report("slot", longint'(want.slot), longint'(i_out_beat.slot));
                    end
                    if (i_out_beat.angle_counts != want.angle_counts) begin
                        report("angle_counts", longint'(want.angle_counts),
                               longint'(i_out_beat.angle_counts));
                    end
                    if (i_out_beat.position_counts != want.position_counts) begin
                        report("position_counts", longint'(want.position_counts),
                               longint'(i_out_beat.position_counts));
                    end
                    if (i_out_beat.speed_filtered != want.speed_filtered) begin
                        report("speed_filtered", longint'(want.speed_filtered),
                               longint'(i_out_beat.speed_filtered));
                    end
                    if (i_out_beat.current_filtered != want.current_filtered) begin
                        report("current_filtered", longint'(want.current_filtered),
                               longint'(i_out_beat.current_filtered));
                    end
                    if (i_out_beat.temperature != want.temperature) begin
                        report("temperature", longint'(want.temperature),
                               longint'(i_out_beat.temperature));
                    end
                end
            end

            // Register writes; unknown indexes are dropped.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLOT_ENABLE: begin
                        regs.slot_enable = i_cfg_data[MaskW-1:0];
                    end
                    CFG_SLOT_WIDE: begin
                        regs.slot_wide = i_cfg_data[MaskW-1:0];
                    end
                    CFG_SPEED_COEF: begin
                        regs.speed_coef = i_cfg_data[CoefW-1:0];
                    end
                    CFG_CURRENT_COEF: begin
                        regs.current_coef = i_cfg_data[CoefW-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Frame beat: predict its result, if any.
            if (i_in_valid && i_in_ready) begin
                if (unwrap_frame(i_in_beat, want)) begin
                    pending_feedback.push_back(want);
                end
            end
        end
        o_pending = pending_feedback.size();
    end

endmodule

`default_nettype wire

// ----- dv/motor_feedback_unwrap_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the motor feedback unwrap block: clock, reset, frame and
// register stimulus, random back-pressure and the final verdict.
// Depends on mfu_pkg, motor_feedback_unwrap and motor_feedback_unwrap_chk.
`default_nettype none

module motor_feedback_unwrap_tb;
    import mfu_pkg::*;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_beat            in_beat   = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    t_out_beat           out_beat;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping: idling switches, current masks, angle walk per slot.
    logic              gaps_on  = 1'b0;
    logic              stall_on = 1'b0;
    logic [MaskW-1:0]  en_now   = '0;
    logic [MaskW-1:0]  wide_now = '0;
    logic [AngleW-1:0] walk_angle [NumSlotsDef];
    int                frames_sent = 0;
    int                settings    = 0;

    motor_feedback_unwrap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    motor_feedback_unwrap_chk chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(20_000_000);
        $display("FAIL");
        $finish;
    end

    // Result back-pressure: mostly short stalls, now and then a long one.
    initial begin : out_stall
        int hold;
        forever begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                hold = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Idle cycles between frames, drawn from a skewed spread.
    task automatic frame_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60) begin
            n = 0;
        end else if (pick < 90) begin
            n = $urandom_range(1, 3);
        end else if (pick < 98) begin
            n = $urandom_range(4, 10);
        end else begin
            n = $urandom_range(20, 60);
        end
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Presents one frame beat and holds it until accepted.
    task automatic send_frame(input t_in_beat f);
        in_valid <= 1'b1;
        in_beat  <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        frames_sent++;
        frame_gap();
    endtask

    // Drains the block before any register write: results first, then the pipe.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Writes all four registers, plus a stray write to an unmapped index at times.
    task automatic apply_setting(input logic [MaskW-1:0] en, input logic [MaskW-1:0] wide,
                                 input logic [CfgDataW-1:0] speed_data,
                                 input logic [CfgDataW-1:0] current_data);
        settle();
        write_reg(CFG_SLOT_ENABLE, en);
        write_reg(CFG_SLOT_WIDE, wide);
        write_reg(CFG_SPEED_COEF, speed_data);
        write_reg(CFG_CURRENT_COEF, current_data);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CfgIdxW'($urandom_range(int'(CFG_CURRENT_COEF) + 1,
                                              (1 << CfgIdxW) - 1)),
                      CfgDataW'($urandom_range(0, (1 << CfgDataW) - 1)));
        end
        en_now   = en;
        wide_now = wide;
        settings++;
    endtask

    function automatic t_in_beat frame_of(input logic [10:0] id, input logic [15:0] angle,
                                          input logic [15:0] speed, input logic [15:0] current,
                                          input logic [7:0] temp);
        t_in_beat f;
        f.frame_id          = id;
        f.byte_angle_high   = angle[15:8];
        f.byte_angle_low    = angle[7:0];
        f.byte_speed_high   = speed[15:8];
        f.byte_speed_low    = speed[7:0];
        f.byte_current_high = current[15:8];
        f.byte_current_low  = current[7:0];
        f.byte_temperature  = temp;
        return f;
    endfunction

    // Random frame. Most frames walk an enabled slot's angle with small steps,
    // near-half-turn jumps or raw values; the rest are noise and stray identifiers.
    function automatic t_in_beat random_frame();
        t_in_beat f;
        int       pick;
        int       s;
        int       span;
        int       a;
        f    = t_in_beat'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return f;
        end else if (pick < 12) begin
            f.frame_id = $urandom_range(0, 1) ? FirstId - 11'd1 : LastId + 11'd1;
            return f;
        end else if (pick < 16) begin
            f.frame_id = FirstId + 11'($urandom_range(0, NumSlotsDef - 1));
            return f;
        end
        s = $urandom_range(0, NumSlotsDef - 1);
        if (en_now != '0) begin
            while (!en_now[s]) s = $urandom_range(0, NumSlotsDef - 1);
        end
        span = wide_now[s] ? int'(EncWide) : int'(EncNarrow);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            a = int'(walk_angle[s]) + $urandom_range(0, 600) - 300;
            a = ((a % span) + span) % span;
        end else if (pick < 90) begin
            a = span / 2 + $urandom_range(0, 6) - 3;
            a = $urandom_range(0, 1) ? int'(walk_angle[s]) + a : int'(walk_angle[s]) - a;
            a = ((a % span) + span) % span;
        end else begin
            a = $urandom_range(0, 65535);
        end
        walk_angle[s] = a[AngleW-1:0];
        f.frame_id        = FirstId + 11'(s);
        f.byte_angle_high = walk_angle[s][15:8];
        f.byte_angle_low  = walk_angle[s][7:0];
        return f;
    endfunction

    initial begin : stimulus
        int n_items;
        logic [MaskW-1:0] en;
        for (int i = 0; i < NumSlotsDef; i++) begin
            walk_angle[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: slots are all disabled straight out of reset.
        send_frame(frame_of(FirstId, 16'h0123, 16'h0001, 16'h0001, 8'd20));

        // Slot 1 disabled, slot 10 on the wide encoder, reset weights kept.
        apply_setting(11'h7FD, 11'h400, CfgDataW'(SpeedCoefReset),
                      CfgDataW'(CurrentCoefReset));
        send_frame(frame_of(FirstId - 11'd1, 16'h1000, 16'h1111, 16'h2222, 8'd1));
        send_frame(frame_of(LastId + 11'd1, 16'h1000, 16'h1111, 16'h2222, 8'd2));
        send_frame(frame_of(11'h000, 16'h0000, 16'h0000, 16'h0000, 8'd0));
        send_frame(frame_of(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255));
        send_frame(frame_of(FirstId + 11'd1, 16'h0100, 16'h0100, 16'h0100, 8'd3));

        // Narrow slot 0: seeding, forward wrap, both exact half turns,
        // just past half, and an angle above the encoder span.
        send_frame(frame_of(FirstId, 16'h1FFF, 16'h7FFF, 16'h7FFF, 8'd255));
        send_frame(frame_of(FirstId, 16'h0000, 16'h8000, 16'h8000, 8'd0));
        send_frame(frame_of(FirstId, 16'd4096, 16'h7FFF, 16'h8000, 8'd40));
        send_frame(frame_of(FirstId, 16'h0000, 16'h8000, 16'h7FFF, 8'd41));
        send_frame(frame_of(FirstId, 16'd4097, 16'h0000, 16'h0000, 8'd42));
        send_frame(frame_of(FirstId, 16'hFFFF, 16'hFFFF, 16'h0001, 8'd43));
        send_frame(frame_of(FirstId, 16'h0000, 16'h0001, 16'hFFFF, 8'd44));

        // Wide slot 10: the same walk against the larger span.
        send_frame(frame_of(LastId, 16'h3FFF, 16'h7FFF, 16'h8000, 8'd90));
        send_frame(frame_of(LastId, 16'h0000, 16'h8000, 16'h7FFF, 8'd91));
        send_frame(frame_of(LastId, 16'd8192, 16'h1234, 16'hEDCB, 8'd92));
        send_frame(frame_of(LastId, 16'h0000, 16'hEDCB, 16'h1234, 8'd93));
        send_frame(frame_of(LastId, 16'd8193, 16'h0000, 16'h0000, 8'd94));
        send_frame(frame_of(LastId, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'd95));

        // Random phases, each under its own register setting and idling mode.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(11'h7FF, 11'h000, 11'h000, 11'h100);
                1: apply_setting(11'h7FF, 11'h7FF, 11'h1FF, 11'h000);
                2: apply_setting(11'h000, MaskW'($urandom_range(0, 2047)),
                                 CfgDataW'($urandom_range(0, 2047)),
                                 CfgDataW'($urandom_range(0, 2047)));
                7: apply_setting(11'h7FF, MaskW'($urandom_range(0, 2047)),
                                 CfgDataW'(SpeedCoefReset), CfgDataW'(CurrentCoefReset));
                default: begin
                    en = MaskW'($urandom_range(0, 2047) | $urandom_range(0, 2047));
                    apply_setting(en, MaskW'($urandom_range(0, 2047)),
                                  CfgDataW'($urandom_range(0, 2047)),
                                  CfgDataW'($urandom_range(0, 2047)));
                end
            endcase
            gaps_on  = (ph % 3) != 0;
            stall_on = (ph % 3) != 1;
            n_items  = (en_now == '0) ? 40 : 215;
            for (int k = 0; k < n_items; k++) begin
                send_frame(random_frame());
            end
        end

        // Drain and give the pipe time to show any stray result.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Ran %0d frames across %0d register settings, with seeding, wrap and",
                 frames_sent, settings);
        $display("filter cases; %0d results compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
